### rtl/lppd_pkg.sv
// ----------------------------------------------------------------------------
// lppd_pkg
// Shared widths, codes and state type of the pairwise point measure block.
// ----------------------------------------------------------------------------
`default_nettype none

package lppd_pkg;

  localparam int COORD_W = 16;
  localparam int PT_W    = 6;
  localparam int DIM_W   = 3;
  localparam int MEAS_W  = 32;
  localparam int ACC_W   = 40;
  localparam int SQ_W    = ACC_W;
  localparam int ROOT_W  = SQ_W / 2;
  localparam int NUM_W   = ACC_W + 8;
  localparam int DEN_W   = ACC_W;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  // store geometry, tied to the point and dimension index field widths
  localparam int MAX_POINTS = 64;
  localparam int MAX_DIMS   = 8;

  localparam logic [1:0] MODE_L1   = 2'd0;
  localparam logic [1:0] MODE_EUC  = 2'd1;
  localparam logic [1:0] MODE_PROJ = 2'd2;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic REG_MODE = 1'b0;
  localparam logic REG_DIMS = 1'b1;

  localparam logic [1:0] MODE_RESET = MODE_EUC;
  localparam logic [3:0] DIMS_RESET = 4'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDA,
    ST_RDB,
    ST_MAC,
    ST_POST,
    ST_SQRT,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

### rtl/lppd_req_if.sv
// ----------------------------------------------------------------------------
// lppd_req_if
// Request channel: load or query items with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface lppd_req_if;
  import lppd_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [PT_W-1:0]           point_a;
  logic [PT_W-1:0]           point_b;
  logic [DIM_W-1:0]          dim_index;
  logic signed [COORD_W-1:0] coord_value;

  modport source (output valid, func, point_a, point_b, dim_index, coord_value,
                  input ready);
  modport sink   (input valid, func, point_a, point_b, dim_index, coord_value,
                  output ready);
endinterface

`default_nettype wire

### rtl/lppd_rsp_if.sv
// ----------------------------------------------------------------------------
// lppd_rsp_if
// Response channel: one measure item per request item.
// ----------------------------------------------------------------------------
`default_nettype none

interface lppd_rsp_if;
  import lppd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [MEAS_W-1:0] measure;
  logic                     zero_norm;

  modport source (output valid, measure, zero_norm, input ready);
  modport sink   (input valid, measure, zero_norm, output ready);
endinterface

`default_nettype wire

### rtl/lppd_store.sv
// ----------------------------------------------------------------------------
// lppd_store
// Coordinate memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module lppd_store #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  wire logic                            clk,
  input  wire logic                            we,
  input  wire logic [AW-1:0]                   waddr,
  input  wire logic [lppd_pkg::COORD_W-1:0]    wdata,
  input  wire logic [AW-1:0]                   raddr,
  output logic      [lppd_pkg::COORD_W-1:0]    rdata
);
  import lppd_pkg::*;

  logic [COORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule

`default_nettype wire

### rtl/lppd_sqrt.sv
// ----------------------------------------------------------------------------
// lppd_sqrt
// Floor integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lppd_sqrt (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [lppd_pkg::SQ_W-1:0]     x,
  output logic                               done,
  output logic      [lppd_pkg::ROOT_W-1:0]   root
);
  import lppd_pkg::*;

  logic [SQ_W-1:0] rem;
  logic [SQ_W-1:0] res;
  logic [SQ_W-1:0] bitv;
  logic            busy;
  logic [SQ_W-1:0] trial;
  logic            ge;

  assign trial = res + bitv;
  assign ge    = rem >= trial;
  assign root  = res[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bitv[0]) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= x;
      res  <= '0;
      bitv <= SQ_W'(1) << (SQ_W - 2);
    end else if (busy) begin
      if (ge) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end
endmodule

`default_nettype wire

### rtl/lppd_div.sv
// ----------------------------------------------------------------------------
// lppd_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lppd_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [lppd_pkg::NUM_W-1:0]   num,
  input  wire logic [lppd_pkg::DEN_W-1:0]   den,
  output logic                              done,
  output logic      [lppd_pkg::NUM_W-1:0]   quo
);
  import lppd_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W:0]   rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   shifted;
  logic             ge;

  assign shifted = {rem[DEN_W-1:0], quo[NUM_W-1]};
  assign ge      = shifted >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
    end else if (busy) begin
      rem <= ge ? shifted - {1'b0, den} : shifted;
      quo <= {quo[NUM_W-2:0], ge};
    end
  end
endmodule

`default_nettype wire

### rtl/latent_point_pair_distance_top.sv
// ----------------------------------------------------------------------------
// latent_point_pair_distance_top
// Point coordinate store with L1, Euclidean and projection pair measures.
// ----------------------------------------------------------------------------
// A query reads, for each of the n dimensions (n is the clamped dimension
// count), the two coordinates in turn through the single read port of the
// coordinate memory, which gives the L1 measure; the Euclidean measure adds
// a pass through the two-bit-per-cycle square root unit and the projection
// ratio a pass through the one-bit-per-cycle divider, unless the norm is zero.
// One item is in work at a time; a finished result waits in the output
// register while the next item is accepted. The memory needs no clearing and
// the block is ready right after reset.
`default_nettype none

module latent_point_pair_distance_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  lppd_req_if.sink                            req,
  lppd_rsp_if.source                          rsp,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [lppd_pkg::APB_AW-1:0]    paddr,
  input  wire logic [lppd_pkg::APB_DW-1:0]    pwdata,
  output logic      [lppd_pkg::APB_DW-1:0]    prdata,
  output logic                                pready
);
  import lppd_pkg::*;

  localparam int DEPTH = MAX_POINTS * MAX_DIMS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_DIMS + 1);

  // configuration registers
  logic [1:0] mode;
  logic [3:0] dims;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_RESET;
      dims <= DIMS_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_MODE: mode <= pwdata[1:0];
        REG_DIMS: dims <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MODE: prdata = {30'd0, mode};
      REG_DIMS: prdata = {28'd0, dims};
      default:  prdata = '0;
    endcase
  end

  logic [CW-1:0] n_clamp;

  always_comb begin
    if (dims == 4'd0) begin
      n_clamp = CW'(1);
    end else if (int'(dims) > MAX_DIMS) begin
      n_clamp = CW'(MAX_DIMS);
    end else begin
      n_clamp = CW'(dims);
    end
  end

  // sequencer and datapath registers
  state_t                    state, state_next;
  logic [PT_W-1:0]           pa_q, pb_q;
  logic                      a_oob, b_oob;
  logic [CW-1:0]             k, n_q;
  logic signed [COORD_W-1:0] coord_a;
  logic signed [ACC_W-1:0]   acc;
  logic [ACC_W-1:0]          norm;
  logic signed [MEAS_W-1:0]  res;
  logic                      zn;
  logic                      out_valid;
  logic signed [MEAS_W-1:0]  out_meas;
  logic                      out_zn;

  logic                      accept;
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr, mem_raddr;
  logic [COORD_W-1:0]        mem_rdata;
  logic                      sq_start, sq_done, dv_start, dv_done;
  logic [ROOT_W-1:0]         sq_root;
  logic [NUM_W-1:0]          dv_quo;
  logic                      out_load;

  assign accept    = req.valid && req.ready;
  assign mem_we    = accept && (req.func == FUNC_LOAD) &&
                     (int'(req.point_a) < MAX_POINTS) && (int'(req.dim_index) < MAX_DIMS);
  assign mem_waddr = AW'(int'(req.point_a) * MAX_DIMS + int'(req.dim_index));
  assign out_load  = (state == ST_DONE) && (!out_valid || rsp.ready);

  lppd_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (req.coord_value),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // per-dimension arithmetic
  logic signed [COORD_W-1:0]   a_v, b_v;
  logic signed [COORD_W:0]     d, absd, mx, my;
  logic signed [2*COORD_W+1:0] prod1;
  logic signed [2*COORD_W-1:0] prod2;
  logic [ACC_W-1:0]            abs_acc;
  logic signed [ACC_W-1:0]     neg_acc;
  logic signed [MEAS_W-1:0]    div_res;

  assign a_v   = a_oob ? '0 : coord_a;
  assign b_v   = b_oob ? '0 : $signed(mem_rdata);
  assign d     = {a_v[COORD_W-1], a_v} - {b_v[COORD_W-1], b_v};
  assign absd  = d[COORD_W] ? -d : d;
  assign mx    = (mode == MODE_EUC) ? d : {a_v[COORD_W-1], a_v};
  assign my    = (mode == MODE_EUC) ? d : {b_v[COORD_W-1], b_v};
  assign prod1 = mx * my;
  assign prod2 = b_v * b_v;

  assign neg_acc = -acc;
  assign abs_acc = acc[ACC_W-1] ? neg_acc : acc;

  // signed result of the projection with 32-bit saturation
  always_comb begin
    if (!acc[ACC_W-1]) begin
      if (dv_quo > NUM_W'(32'h7FFF_FFFF)) begin
        div_res = 32'sh7FFF_FFFF;
      end else begin
        div_res = dv_quo[MEAS_W-1:0];
      end
    end else begin
      if (dv_quo >= NUM_W'(33'h0_8000_0000)) begin
        div_res = 32'sh8000_0000;
      end else begin
        div_res = 32'd0 - dv_quo[MEAS_W-1:0];
      end
    end
  end

  lppd_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .x     (acc),
    .done  (sq_done),
    .root  (sq_root)
  );

  lppd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .num   ({abs_acc, 8'd0}),
    .den   (norm),
    .done  (dv_done),
    .quo   (dv_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    mem_raddr  = AW'(int'(pa_q) * MAX_DIMS + int'(k));
    sq_start   = 1'b0;
    dv_start   = 1'b0;
    case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = (req.func == FUNC_LOAD) ? ST_DONE : ST_RDA;
        end
      end
      ST_RDA: begin
        state_next = ST_RDB;
      end
      ST_RDB: begin
        mem_raddr  = AW'(int'(pb_q) * MAX_DIMS + int'(k));
        state_next = ST_MAC;
      end
      ST_MAC: begin
        state_next = (k == n_q - CW'(1)) ? ST_POST : ST_RDA;
      end
      ST_POST: begin
        case (mode)
          MODE_EUC: begin
            sq_start   = 1'b1;
            state_next = ST_SQRT;
          end
          MODE_PROJ: begin
            if (norm == '0) begin
              state_next = ST_DONE;
            end else begin
              dv_start   = 1'b1;
              state_next = ST_DIV;
            end
          end
          default: state_next = ST_DONE;
        endcase
      end
      ST_SQRT: begin
        if (sq_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DIV: begin
        if (dv_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pa_q  <= req.point_a;
      pb_q  <= req.point_b;
      a_oob <= int'(req.point_a) >= MAX_POINTS;
      b_oob <= int'(req.point_b) >= MAX_POINTS;
      k     <= '0;
      n_q   <= n_clamp;
      acc   <= '0;
      norm  <= '0;
      res   <= '0;
      zn    <= 1'b0;
    end else begin
      case (state)
        ST_RDB: coord_a <= $signed(mem_rdata);
        ST_MAC: begin
          k <= k + CW'(1);
          case (mode)
            MODE_L1:  acc <= acc + ACC_W'(absd);
            MODE_EUC: acc <= acc + ACC_W'(prod1);
            MODE_PROJ: begin
              acc  <= acc + ACC_W'(prod1);
              norm <= norm + ACC_W'($unsigned(prod2));
            end
            default: ;
          endcase
        end
        ST_POST: begin
          case (mode)
            MODE_L1:   res <= neg_acc[MEAS_W-1:0];
            MODE_PROJ: zn  <= (norm == '0);
            default: ;
          endcase
        end
        ST_SQRT: if (sq_done) res <= 32'd0 - MEAS_W'(sq_root);
        ST_DIV:  if (dv_done) res <= div_res;
        default: ;
      endcase
    end
  end

  // output register parts the result from the next request
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_meas <= res;
      out_zn   <= zn;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.measure   = out_meas;
  assign rsp.zero_norm = out_zn;
endmodule

`default_nettype wire

### rtl/lppd_checker.sv
// ----------------------------------------------------------------------------
// lppd_checker
// Port-level checks of the pairwise point measure block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module lppd_port_props (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [31:0] rsp_measure,
  input wire logic        rsp_zero_norm
);

  // result held until taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_measure) && $stable(rsp_zero_norm))
    else $error("response payload changed while stalled");

  a_zero_norm: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_zero_norm |-> rsp_measure == 32'd0)
    else $error("zero norm flagged with nonzero measure");

  a_reset: assert property (@(posedge clk)
    rst |=> req_ready && !rsp_valid)
    else $error("block not idle after reset");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second item accepted while busy");

endmodule

bind latent_point_pair_distance_top lppd_port_props u_lppd_port_props (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_measure   (rsp.measure),
  .rsp_zero_norm (rsp.zero_norm)
);

`default_nettype wire
